### sv/fir16_pkg.sv
// Shared types, widths and constants for the 16-bit direct-form FIR filter.
package fir16_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int FRAC_W      = 15;
  localparam int TAP_CNT_W   = 7;
  localparam int COEF_IDX_W  = 6;
  localparam int MAX_TAPS_DEF = 64;

  localparam logic [TAP_CNT_W-1:0] TAP_CNT_RST = 7'd63;

  // Half an output LSB at the Q2.30 product scale.
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);
  // Added to negative sums so that the arithmetic shift truncates toward zero.
  localparam int TRUNC_BIAS = (1 << FRAC_W) - 1;
  // Saturation limits at the product scale.
  localparam longint SAT_HI_VAL = 64'sd1073709056;
  localparam longint SAT_LO_VAL = -64'sd1073741824;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } fsm_state_t;

  typedef struct packed {
    logic clr;
    logic vld;
    logic hok;
  } mac_ctl_t;

  function automatic int acc_width(input int max_taps);
    return PROD_W + $clog2(max_taps) + 1;
  endfunction

endpackage

### sv/fir16_mac.sv
// Shared multiply-accumulate unit: one registered product, one accumulator.
module fir16_mac #(
  parameter int MAX_TAPS = fir16_pkg::MAX_TAPS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  fir16_pkg::mac_ctl_t                             ctl,
  input  logic signed [fir16_pkg::COEF_W-1:0]             coef,
  input  logic signed [fir16_pkg::SAMPLE_W-1:0]           sample,
  output logic                                            busy,
  output logic signed [fir16_pkg::acc_width(MAX_TAPS)-1:0] acc
);
  import fir16_pkg::*;

  localparam int AccW = acc_width(MAX_TAPS);

  logic signed [SAMPLE_W-1:0] smp_m;
  logic signed [PROD_W-1:0]   prod;
  logic                       p_vld;

  // History entries not yet written since reset count as zero.
  assign smp_m = ctl.hok ? sample : '0;
  assign busy  = p_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(coef) * PROD_W'(smp_m);
    if (ctl.clr) begin
      acc <= AccW'(ROUND_HALF);
    end else if (p_vld) begin
      acc <= acc + AccW'(prod);
    end
  end

endmodule

### sv/fir_filter_int16.sv
// Top level of the 16-bit direct-form FIR filter with a shared MAC.
//
// Input requests carry mode, sample_in, coef_index and coef_value and are
// taken when in_valid is high and in_stall is low. A coefficient request
// (mode 1) writes one Q1.15 tap and gives no result; an
// index at or beyond MAX_TAPS is dropped. A sample request (mode 0) gives
// exactly one output request carrying sample_out and clipped.
// A sample passes through one MAC step per tap, reading one coefficient and
// one history word per cycle, then drains the read and product registers,
// loads the output register and goes back to idle to take the next request.
// in_stall stays high while a sample is in the MAC loop.
// The output register holds the result until out_stall drops; the next
// request may be taken meanwhile, but a finished sum waits in the loop until
// the output register is free.
// tap_count is written through cfg_wr_en / cfg_wr_data; the user must write it only while idle, as the
// block itself does not enforce this. Zero acts as one tap and values above MAX_TAPS act as MAX_TAPS.
// rst sets tap_count to 63 and empties the sample history; coefficients are
// undefined until written.
module fir_filter_int16 #(
  parameter int MAX_TAPS = fir16_pkg::MAX_TAPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [fir16_pkg::TAP_CNT_W-1:0]       cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  mode,
  input  logic signed [fir16_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [fir16_pkg::COEF_IDX_W-1:0]      coef_index,
  input  logic signed [fir16_pkg::COEF_W-1:0]   coef_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fir16_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                  clipped
);
  import fir16_pkg::*;

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = acc_width(MAX_TAPS);
  localparam logic [AW-1:0] LastAddr = AW'(MAX_TAPS - 1);
  localparam logic signed [ACC_W-1:0] SatHi = ACC_W'(SAT_HI_VAL);
  localparam logic signed [ACC_W-1:0] SatLo = ACC_W'(SAT_LO_VAL);

  fsm_state_t state, state_next;

  logic [TAP_CNT_W-1:0] tap_count;
  logic [CW-1:0]        taps_eff;
  logic [CW-1:0]        taps;
  logic [CW-1:0]        k;
  logic [AW-1:0]        wp;
  logic [AW-1:0]        rp;
  logic [AW-1:0]        fill;
  logic                 rd_vld;
  logic                 rd_hok;
  logic                 rd_en;
  logic                 load_out;

  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_q;
  logic signed [COEF_W-1:0]   coef_q;

  logic                    in_acc;
  logic                    smp_acc;
  logic                    coef_acc;
  logic                    last_issue;
  logic                    pipe_empty;
  logic                    out_free;
  logic                    mac_busy;
  mac_ctl_t                mac_ctl;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] trunc;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                    y_clip;

  assign in_acc     = in_valid && !in_stall;
  assign smp_acc    = in_acc && (mode == MODE_SAMPLE);
  assign coef_acc   = in_acc && (mode == MODE_COEF) && (int'(coef_index) < MAX_TAPS);
  assign last_issue = (k == taps - CW'(1));
  assign pipe_empty = !rd_vld && !mac_busy;
  assign out_free   = !out_valid || !out_stall;

  always_comb begin
    if (tap_count == '0) begin
      taps_eff = CW'(1);
    end else if (int'(tap_count) > MAX_TAPS) begin
      taps_eff = CW'(MAX_TAPS);
    end else begin
      taps_eff = CW'(tap_count);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (smp_acc) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_RUN:   rd_en    = 1'b1;
      ST_DRAIN: load_out = pipe_empty && out_free;
      default:  in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap_count <= TAP_CNT_RST;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        tap_count <= cfg_wr_data;
      end
    end
  end

  // The history is a ring: the write pointer moves instead of the samples,
  // and the read pointer walks backward from the newest sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      rp     <= '0;
      k      <= '0;
      taps   <= '0;
      fill   <= '0;
      rd_vld <= 1'b0;
      rd_hok <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      rd_hok <= (k <= CW'(fill));
      if (smp_acc) begin
        wp   <= (wp == LastAddr) ? '0 : wp + AW'(1);
        rp   <= wp;
        k    <= '0;
        taps <= taps_eff;
      end
      if (rd_en) begin
        k  <= k + CW'(1);
        rp <= (rp == '0) ? LastAddr : rp - AW'(1);
      end
      if (load_out && (fill != LastAddr)) begin
        fill <= fill + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_acc) begin
      hist_mem[wp] <= sample_in;
    end
    if (coef_acc) begin
      coef_mem[AW'(coef_index)] <= coef_value;
    end
    if (rd_en) begin
      hist_q <= hist_mem[rp];
      coef_q <= coef_mem[k[AW-1:0]];
    end
  end

  assign mac_ctl.clr = smp_acc;
  assign mac_ctl.vld = rd_vld;
  assign mac_ctl.hok = rd_hok;

  fir16_mac #(
    .MAX_TAPS(MAX_TAPS)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mac_ctl),
    .coef  (coef_q),
    .sample(hist_q),
    .busy  (mac_busy),
    .acc   (acc)
  );

  // Saturate first, then shift down with truncation toward zero.
  always_comb begin
    trunc  = acc + (acc[ACC_W-1] ? ACC_W'(TRUNC_BIAS) : '0);
    y_clip = 1'b0;
    if (acc > SatHi) begin
      y_sat  = SAMPLE_MAX;
      y_clip = 1'b1;
    end else if (acc < SatLo) begin
      y_sat  = SAMPLE_MIN;
      y_clip = 1'b1;
    end else begin
      y_sat = trunc[FRAC_W+SAMPLE_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample_out <= y_sat;
      clipped    <= y_clip;
    end
  end

  a_rd_from_run: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state) == ST_RUN)
    else $error("history read issued outside the MAC loop");

  a_out_from_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DRAIN)
    else $error("result appeared without a finished sum");

  a_tap_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> (k < taps) && (taps != '0))
    else $error("tap counter ran past the tap count");

  a_clr_idle: assert property (@(posedge clk) disable iff (rst)
    mac_ctl.clr |-> !mac_busy && !rd_vld)
    else $error("accumulator cleared while products were in flight");

endmodule
